/* hdl/pitt_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic interval timer table package
// Shared widths, operation and result codes, the table entry layout, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pitt_pkg;

  // Field widths of the input and result beats.
  localparam int OP_W      = 2;
  localparam int ELAPSED_W = 8;
  localparam int PERIOD_W  = 24;
  localparam int ID_W      = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;

  // Accumulator width and its saturation value.
  localparam int ACC_W = 25;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Default table depth and the cap on fire events reported per tick.
  localparam int MAX_TIMERS_DEF = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int NFIRE_W        = $clog2(RESULT_LIMIT + 1);

  // Operation codes carried on the input side.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  // One table entry as stored in the timer memory.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
    logic [ACC_W-1:0]    acc;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat and arm a new walk
    logic do_add;  // append an entry, or report a full table
    logic walk;    // step through the table entries
    logic finish;  // close out a clear or flush the last fire event
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic walk_done;  // every live entry has been processed
    logic fin_emit;   // the closing step produces a result beat
  } stat_t;

endpackage

/* hdl/pitt_ctrl.sv */
// ----------------------------------------------------------------------------
// Periodic interval timer table controller
// Sequences each input beat: an add step, or a walk over the table followed
// by a closing step, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module pitt_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [pitt_pkg::OP_W-1:0]    in_op,
  output logic                         in_ready,
  input  pitt_pkg::stat_t              st,
  output pitt_pkg::cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            pitt_pkg::OP_ADD:   state_next = S_ADD;
            pitt_pkg::OP_TICK:  state_next = S_WALK;
            pitt_pkg::OP_CLEAR: state_next = S_WALK;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (st.out_free) begin
          cmd.do_add = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.fin_emit || st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pitt_dp.sv */
// ----------------------------------------------------------------------------
// Periodic interval timer table datapath
// Holds the timer memory, live count, id counter, walk read pipeline (one
// entry per cycle unless output stalls), pending fire event, output register.
// ----------------------------------------------------------------------------
module pitt_dp #(
  parameter int MAX_TIMERS = pitt_pkg::MAX_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pitt_pkg::cmd_t                   cmd,
  output pitt_pkg::stat_t                  st,
  input  logic [pitt_pkg::OP_W-1:0]        in_op,
  input  logic [pitt_pkg::ELAPSED_W-1:0]   in_elapsed,
  input  logic [pitt_pkg::PERIOD_W-1:0]    in_period,
  input  logic [pitt_pkg::ID_W-1:0]        in_tid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pitt_pkg::KIND_W-1:0]      out_kind,
  output logic [pitt_pkg::ID_W-1:0]        out_id,
  output logic [pitt_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_last
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int AW = pitt_pkg::ACC_W;
  localparam int NW = pitt_pkg::NFIRE_W;

  // Captured input beat.
  logic [pitt_pkg::OP_W-1:0]      op_q;
  logic [pitt_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [pitt_pkg::PERIOD_W-1:0]  period_q;
  logic [pitt_pkg::ID_W-1:0]      tid_q;

  // Table state.
  logic [CW-1:0]               count;
  logic [pitt_pkg::ID_W-1:0]   next_id;
  pitt_pkg::entry_t            mem [MAX_TIMERS];

  // Walk pipeline: issue index, then registered read data.
  logic [CW-1:0]       rd_idx;
  logic                s1_v;
  logic [IW-1:0]       s1_idx;
  pitt_pkg::entry_t    s1_data;
  logic                found;
  logic                hold_v;
  logic [pitt_pkg::ID_W-1:0] hold_id;
  logic [NW-1:0]       nfire;

  // Output register.
  logic                              out_v;
  logic [pitt_pkg::KIND_W-1:0]       out_kind_q;
  logic [pitt_pkg::ID_W-1:0]         out_id_q;
  logic [pitt_pkg::STATUS_W-1:0]     out_status_q;
  logic                              out_last_q;

  // Datapath control signals.
  logic                      out_free;
  logic                      full;
  logic                      issue;
  logic                      is_tick;
  logic                      is_clear;
  logic [AW:0]               acc_sum;
  logic [AW-1:0]             acc_sat;
  logic                      fire;
  logic                      report;
  logic                      push_hold;
  logic                      stall;
  logic                      adv;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic                      match;
  logic [pitt_pkg::ID_W-1:0] id_inc;
  logic                      we;
  logic [IW-1:0]             wr_addr;
  pitt_pkg::entry_t          wr_data;
  logic                      out_load;
  logic [pitt_pkg::KIND_W-1:0]   ld_kind;
  logic [pitt_pkg::ID_W-1:0]     ld_id;
  logic [pitt_pkg::STATUS_W-1:0] ld_status;
  logic                          ld_last;

  // Conditions of the current step.
  always_comb begin
    out_free  = !out_v || out_ready;
    full      = (count == CW'(MAX_TIMERS));
    issue     = (rd_idx < count);
    is_tick   = (op_q == pitt_pkg::OP_TICK);
    is_clear  = (op_q == pitt_pkg::OP_CLEAR);
    acc_sum   = {1'b0, s1_data.acc} + (AW + 1)'(elapsed_q);
    acc_sat   = acc_sum[AW] ? pitt_pkg::ACC_MAX : acc_sum[AW-1:0];
    fire      = (acc_sat >= AW'(s1_data.period));
    report    = fire && (nfire < NW'(pitt_pkg::RESULT_LIMIT));
    push_hold = s1_v && is_tick && report && hold_v;
    stall     = push_hold && !out_free;
    adv       = cmd.walk && !stall;
    rd_en     = adv && issue;
    rd_addr   = rd_idx[IW-1:0];
    match     = (s1_data.id == tid_q);
    id_inc    = next_id + pitt_pkg::ID_W'(1);
  end

  // Memory write port: append on add, accumulator update on tick, and the
  // shift-down of later entries once a clear has found its match.
  always_comb begin
    we      = 1'b0;
    wr_addr = s1_idx;
    wr_data = s1_data;
    if (cmd.do_add && !full) begin
      we             = 1'b1;
      wr_addr        = count[IW-1:0];
      wr_data.id     = id_inc;
      wr_data.period = period_q;
      wr_data.acc    = '0;
    end else if (adv && s1_v) begin
      if (is_tick) begin
        we          = 1'b1;
        wr_data.acc = fire ? '0 : acc_sat;
      end else if (found) begin
        we      = 1'b1;
        wr_addr = s1_idx - IW'(1);
      end
    end
  end

  // Result selection for the output register.
  always_comb begin
    out_load  = 1'b0;
    ld_kind   = pitt_pkg::KIND_FIRE;
    ld_id     = hold_id;
    ld_status = pitt_pkg::STAT_OK;
    ld_last   = 1'b0;
    if (cmd.do_add) begin
      out_load  = 1'b1;
      ld_kind   = pitt_pkg::KIND_ADD;
      ld_id     = full ? '0 : id_inc;
      ld_status = full ? pitt_pkg::STAT_FULL : pitt_pkg::STAT_OK;
      ld_last   = 1'b1;
    end else if (adv && push_hold) begin
      out_load = 1'b1;
    end else if (cmd.finish) begin
      if (is_clear) begin
        out_load  = 1'b1;
        ld_kind   = pitt_pkg::KIND_CLEAR;
        ld_id     = tid_q;
        ld_status = found ? pitt_pkg::STAT_OK : pitt_pkg::STAT_NOT_FOUND;
        ld_last   = 1'b1;
      end else if (hold_v) begin
        out_load = 1'b1;
        ld_last  = 1'b1;
      end
    end
  end

  // Timer memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      s1_data <= mem[rd_addr];
    end
  end

  // Captured beat and entry payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= in_op;
      elapsed_q <= in_elapsed;
      period_q  <= in_period;
      tid_q     <= in_tid;
    end
    if (adv && issue) begin
      s1_idx <= rd_idx[IW-1:0];
    end
    if (adv && s1_v && is_tick && report) begin
      hold_id <= s1_data.id;
    end
    if (out_load) begin
      out_kind_q   <= ld_kind;
      out_id_q     <= ld_id;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
    end
  end

  // Control state of the table and the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= '0;
      rd_idx  <= '0;
      s1_v    <= 1'b0;
      found   <= 1'b0;
      hold_v  <= 1'b0;
      nfire   <= '0;
      out_v   <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx <= '0;
        s1_v   <= 1'b0;
        found  <= 1'b0;
        hold_v <= 1'b0;
        nfire  <= '0;
      end
      if (cmd.do_add && !full) begin
        count   <= count + CW'(1);
        next_id <= id_inc;
      end
      if (adv) begin
        s1_v <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (s1_v) begin
          if (is_tick && report) begin
            nfire  <= nfire + NW'(1);
            hold_v <= 1'b1;
          end else if (is_clear && !found && match) begin
            found <= 1'b1;
          end
        end
      end
      if (cmd.finish && is_clear && found) begin
        count <= count - CW'(1);
      end
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    st.out_free  = out_free;
    st.walk_done = !s1_v && !issue;
    st.fin_emit  = is_clear || hold_v;
  end

  assign out_valid  = out_v;
  assign out_kind   = out_kind_q;
  assign out_id     = out_id_q;
  assign out_status = out_status_q;
  assign out_last   = out_last_q;

endmodule

/* hdl/periodic_interval_timer_table.sv */
// Sequence: an add loads its acknowledge in the add step after its beat is accepted;
// a clear or a tick walks the live entries one per cycle unless a stalled output
// holds the walk, then loads its last result, if any, in the closing step.
// One item is handled at a time; the next is accepted after that load.
// A stalled output holds the work until taken.
// Reset (rst, synchronous) empties the table and zeroes the id counter.
// ----------------------------------------------------------------------------
// Periodic interval timer table
// Keeps up to MAX_TIMERS periodic timers in insertion order; handles add,
// clear and tick beats and streams out acknowledges and fire events.
// ----------------------------------------------------------------------------
module periodic_interval_timer_table #(
  parameter int MAX_TIMERS = pitt_pkg::MAX_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // elapsed_ms[7:0], period_ms[31:8], timer_id[47:32]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_id[15:0], status[17:16], zero fill[23:18]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  pitt_pkg::cmd_t  cmd;
  pitt_pkg::stat_t st;

  logic [pitt_pkg::ID_W-1:0]     res_id;
  logic [pitt_pkg::STATUS_W-1:0] res_status;

  // Sequencer.
  pitt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Table storage and result path.
  pitt_dp #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_op      (s_tuser),
    .in_elapsed (s_tdata[7:0]),
    .in_period  (s_tdata[31:8]),
    .in_tid     (s_tdata[47:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_id     (res_id),
    .out_status (res_status),
    .out_last   (m_tlast)
  );

  // Pack the result beat.
  assign m_tdata = {6'd0, res_status, res_id};

`ifndef ASSERT_OFF
  // An add or clear acknowledge is always the only result of its beat.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pitt_pkg::KIND_ADD || m_tuser == pitt_pkg::KIND_CLEAR)
    |-> m_tlast)
    else $error("acknowledge beat without tlast");

  // Fire events always carry an ok status.
  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pitt_pkg::KIND_FIRE |-> m_tdata[17:16] == pitt_pkg::STAT_OK)
    else $error("fire event with non-ok status");

  // An accepted add keeps the input closed for at least the next cycle.
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == pitt_pkg::OP_ADD |=> !s_tready)
    else $error("input reopened during add");

  // A walk never runs while the input side is open.
  a_walk_closed: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> !s_tready)
    else $error("walk active while accepting");
`endif

endmodule
